// ===== design/clsd_pkg.sv =====
// Constants, codes and character helpers for the content-length deframer.
package clsd_pkg;

	localparam int unsigned LENGTH_BITS = 31;

	localparam logic [15:0] MAX_HDR_RESET = 16'd8192;
	localparam logic [30:0] MAX_MSG_RESET = 31'd67108864;

	localparam logic [30:0] LEN_CAP = 31'((64'd1 << LENGTH_BITS) - 64'd1);

	// config register indexes
	localparam logic CFG_MAX_HDR = 1'b0;
	localparam logic CFG_MAX_MSG = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_BODY    = 2'd0;
	localparam logic [1:0] KIND_NO_TERM = 2'd1;
	localparam logic [1:0] KIND_BAD_LEN = 2'd2;

	// phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_DEAD   = 2'd2;

	// line scanner states; 1..14 are prefix characters matched
	localparam logic [4:0] LS_LEAD   = 5'd0;
	localparam logic [4:0] LS_KEYEND = 5'd14;
	localparam logic [4:0] LS_AFTER  = 5'd15;
	localparam logic [4:0] LS_SIGN   = 5'd16;
	localparam logic [4:0] LS_DIGITS = 5'd17;
	localparam logic [4:0] LS_TRAIL  = 5'd18;
	localparam logic [4:0] LS_SKIP   = 5'd19;
	localparam logic [4:0] LS_DONE   = 5'd20;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// "Content-Length:"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = 8'h43;
			4'd1:    ch = 8'h6F;
			4'd2:    ch = 8'h6E;
			4'd3:    ch = 8'h74;
			4'd4:    ch = 8'h65;
			4'd5:    ch = 8'h6E;
			4'd6:    ch = 8'h74;
			4'd7:    ch = 8'h2D;
			4'd8:    ch = 8'h4C;
			4'd9:    ch = 8'h65;
			4'd10:   ch = 8'h6E;
			4'd11:   ch = 8'h67;
			4'd12:   ch = 8'h74;
			4'd13:   ch = 8'h68;
			4'd14:   ch = 8'h3A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// CR LF CR LF
	function automatic logic [7:0] term_char(input logic [1:0] idx);
		return idx[0] ? CH_LF : CH_CR;
	endfunction

endpackage

// ===== design/content_length_stream_deframer.sv =====
// Top level of the content-length stream deframer.
// Takes one stream byte per cycle while no result waits on out_ready; each byte's result is
// then registered; the rate is set by the per-byte header scanner and length accumulator,
// which update once for every byte between the input register and the result register.
// Header bytes and bytes after an error give no result; each body byte gives one result
// with first and last marks, and an error gives one result after which all input is
// taken and dropped until reset. Register writes take effect at once. No clearing pass
// is needed after reset.
module content_length_stream_deframer
	import clsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        first_of_body,
	output logic        last_of_body,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	logic [15:0] max_hdr_q;
	logic [30:0] max_msg_q;

	logic [1:0]  phase_q, phase_n;
	logic [16:0] hc_q, hc_n;
	logic [1:0]  tm_q, tm_n;
	logic [4:0]  ls_q, ls_n;
	logic        found_q, found_n;
	logic [31:0] lv_q, lv_n;
	logic        neg_q, neg_n;
	logic        inval_q, inval_n;
	logic [LENGTH_BITS-1:0] br_q, br_n;
	logic        started_q, started_n;

	logic        res_v;
	logic [1:0]  res_kind;
	logic [7:0]  res_data;
	logic        res_first;
	logic        res_last;

	logic [35:0] acc;
	logic [2:0]  tm_next;
	logic [30:0] lim;
	logic        bad;
	logic [LENGTH_BITS-1:0] br_dec;

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign acc     = ({4'd0, lv_q} << 3) + ({4'd0, lv_q} << 1) + {28'd0, byte_s1 - CH_ZERO};
	assign tm_next = (byte_s1 == term_char(tm_q)) ? ({1'b0, tm_q} + 3'd1)
	                                              : ((byte_s1 == CH_CR) ? 3'd1 : 3'd0);
	assign lim     = (max_msg_q < LEN_CAP) ? max_msg_q : LEN_CAP;
	assign br_dec  = br_q - LENGTH_BITS'(1);

	always_comb begin
		phase_n   = phase_q;
		hc_n      = hc_q;
		tm_n      = tm_q;
		ls_n      = ls_q;
		found_n   = found_q;
		lv_n      = lv_q;
		neg_n     = neg_q;
		inval_n   = inval_q;
		br_n      = br_q;
		started_n = started_q;
		res_v     = 1'b0;
		res_kind  = KIND_BODY;
		res_data  = 8'd0;
		res_first = 1'b0;
		res_last  = 1'b0;
		bad       = 1'b0;

		if (phase_q == PH_BODY) begin
			res_v     = 1'b1;
			res_data  = byte_s1;
			res_first = !started_q;
			res_last  = (br_q == LENGTH_BITS'(1));
			started_n = 1'b1;
			br_n      = br_dec;
			if (br_dec == '0) begin
				phase_n   = PH_HEADER;
				hc_n      = '0;
				tm_n      = '0;
				ls_n      = LS_LEAD;
				found_n   = 1'b0;
				lv_n      = '0;
				neg_n     = 1'b0;
				inval_n   = 1'b0;
				started_n = 1'b0;
			end
		end else if (phase_q == PH_HEADER) begin
			if (!hc_q[16])
				hc_n = hc_q + 17'd1;

			priority if (byte_s1 == CH_LF) begin
				if (ls_q == LS_AFTER || ls_q == LS_SIGN)
					inval_n = 1'b1;
				ls_n = found_q ? LS_DONE : LS_LEAD;
			end else if (ls_q == LS_DONE || ls_q == LS_SKIP) begin
				ls_n = ls_q;
			end else if (ls_q == LS_LEAD) begin
				if (!is_space(byte_s1))
					ls_n = (byte_s1 == key_char(4'd0)) ? 5'd1 : LS_SKIP;
			end else if (ls_q < LS_AFTER) begin
				if (byte_s1 == key_char(ls_q[3:0])) begin
					ls_n = ls_q + 5'd1;
					if (ls_q == LS_KEYEND)
						found_n = 1'b1;
				end else begin
					ls_n = LS_SKIP;
				end
			end else if (ls_q == LS_AFTER && is_space(byte_s1)) begin
				ls_n = ls_q;
			end else if (ls_q == LS_AFTER && (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS)) begin
				if (byte_s1 == CH_MINUS)
					neg_n = 1'b1;
				ls_n = LS_SIGN;
			end else if ((ls_q == LS_AFTER || ls_q == LS_SIGN || ls_q == LS_DIGITS) &&
			             byte_s1 >= CH_ZERO && byte_s1 <= CH_NINE) begin
				lv_n = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
				ls_n = LS_DIGITS;
			end else if ((ls_q == LS_DIGITS || ls_q == LS_TRAIL) && is_space(byte_s1)) begin
				ls_n = LS_TRAIL;
			end else begin
				inval_n = 1'b1;
				ls_n    = LS_TRAIL;
			end

			tm_n = tm_next[1:0];

			if (tm_next[2]) begin
				bad = !found_n || inval_n || (neg_n && lv_n != 32'd0) || (lv_n > {1'b0, lim});
				if (bad) begin
					res_v    = 1'b1;
					res_kind = KIND_BAD_LEN;
					phase_n  = PH_DEAD;
				end else if (lv_n == 32'd0) begin
					hc_n      = '0;
					tm_n      = '0;
					ls_n      = LS_LEAD;
					found_n   = 1'b0;
					lv_n      = '0;
					neg_n     = 1'b0;
					inval_n   = 1'b0;
					br_n      = '0;
					started_n = 1'b0;
				end else begin
					br_n      = lv_n[LENGTH_BITS-1:0];
					started_n = 1'b0;
					phase_n   = PH_BODY;
				end
			end else if (hc_n > {1'b0, max_hdr_q}) begin
				res_v    = 1'b1;
				res_kind = KIND_NO_TERM;
				phase_n  = PH_DEAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= MAX_HDR_RESET;
			max_msg_q <= MAX_MSG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_HDR: max_hdr_q <= cfg_data[15:0];
				CFG_MAX_MSG: max_msg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hc_q      <= '0;
			tm_q      <= '0;
			ls_q      <= LS_LEAD;
			found_q   <= 1'b0;
			lv_q      <= '0;
			neg_q     <= 1'b0;
			inval_q   <= 1'b0;
			br_q      <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_n;
			hc_q      <= hc_n;
			tm_q      <= tm_n;
			ls_q      <= ls_n;
			found_q   <= found_n;
			lv_q      <= lv_n;
			neg_q     <= neg_n;
			inval_q   <= inval_n;
			br_q      <= br_n;
			started_q <= started_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res_v;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			kind          <= res_kind;
			data_byte     <= res_data;
			first_of_body <= res_first;
			last_of_body  <= res_last;
		end
	end

`ifndef SYNTHESIS
	a_dead_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DEAD |=> phase_q == PH_DEAD)
		else $error("left dead phase without reset");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BODY |-> data_byte == 8'd0 && !first_of_body &&
		!last_of_body && phase_q == PH_DEAD)
		else $error("error beat with body marks or live phase");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> br_q != '0)
		else $error("body phase with nothing remaining");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the content-length deframer: byte streams in, beats checked.
`timescale 1ns / 1ps

module tb_top
	import clsd_pkg::*;
();

	localparam int STALL_LIMIT = 1000;
	localparam logic [119:0] CL_KEY = "Content-Length:";

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       first;
		logic       last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        first_of_body;
	logic        last_of_body;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [30:0] cfg_data = 31'd0;

	content_length_stream_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.data_byte     (data_byte),
		.first_of_body (first_of_body),
		.last_of_body  (last_of_body),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0] stream_q[$];
	logic [7:0] stage[$];
	beat_t      due_beats[$];
	beat_t      want;
	int         fed = 0;
	int         errors = 0;
	int         stuck;
	bit         calm = 1'b0;
	int         src_gap = 0, src_rate = 0, src_span = 0;
	int         snk_gap = 0, snk_rate = 0, snk_span = 0;

	// deframer state as tracked by the testbench
	logic [15:0] lim_hdr;
	logic [30:0] lim_body;
	logic [1:0]  m_phase;
	int          hdr_cnt;
	int          term_m;
	logic [4:0]  ln_st;
	bit          len_found, len_neg, len_bad, body_go;
	logic [31:0] len_val;
	logic [30:0] body_left;

	function automatic logic [7:0] key_at(input int i);
		return CL_KEY[8*(14-i) +: 8];
	endfunction

	task automatic fresh_header();
		hdr_cnt = 0;
		term_m = 0;
		ln_st = LS_LEAD;
		len_found = 1'b0;
		len_val = 32'd0;
		len_neg = 1'b0;
		len_bad = 1'b0;
		body_left = 31'd0;
		body_go = 1'b0;
	endtask

	task automatic restart_model();
		lim_hdr = MAX_HDR_RESET;
		lim_body = MAX_MSG_RESET;
		m_phase = PH_HEADER;
		fresh_header();
	endtask

	task automatic deframe_byte(input logic [7:0] c);
		beat_t       b;
		bit          ws, bad;
		logic [63:0] acc;
		logic [30:0] lim;
		ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		b = '0;
		if (m_phase == PH_BODY) begin
			b.kind = KIND_BODY;
			b.data = c;
			b.first = !body_go;
			b.last = (body_left == 31'd1);
			due_beats.push_back(b);
			body_go = 1'b1;
			body_left = body_left - 31'd1;
			if (body_left == 31'd0) begin
				m_phase = PH_HEADER;
				fresh_header();
			end
		end else if (m_phase == PH_HEADER) begin
			if (hdr_cnt <= 32'hFFFF)
				hdr_cnt++;
			if (c == CH_LF) begin
				if (ln_st == LS_AFTER || ln_st == LS_SIGN)
					len_bad = 1'b1;
				ln_st = len_found ? LS_DONE : LS_LEAD;
			end else if (ln_st == LS_DONE || ln_st == LS_SKIP) begin
			end else if (ln_st == LS_LEAD) begin
				if (!ws)
					ln_st = (c == key_at(0)) ? 5'd1 : LS_SKIP;
			end else if (ln_st < LS_AFTER) begin
				if (c == key_at(ln_st)) begin
					ln_st = ln_st + 5'd1;
					if (ln_st == LS_AFTER)
						len_found = 1'b1;
				end else
					ln_st = LS_SKIP;
			end else if (ln_st == LS_AFTER && ws) begin
			end else if (ln_st == LS_AFTER && (c == CH_PLUS || c == CH_MINUS)) begin
				if (c == CH_MINUS)
					len_neg = 1'b1;
				ln_st = LS_SIGN;
			end else if ((ln_st == LS_AFTER || ln_st == LS_SIGN || ln_st == LS_DIGITS)
					&& c >= CH_ZERO && c <= CH_NINE) begin
				acc = 64'(len_val) * 64'd10 + 64'(c - CH_ZERO);
				len_val = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
				ln_st = LS_DIGITS;
			end else if ((ln_st == LS_DIGITS || ln_st == LS_TRAIL) && ws) begin
				ln_st = LS_TRAIL;
			end else begin
				len_bad = 1'b1;
				ln_st = LS_TRAIL;
			end

			if (c == (term_m[0] ? CH_LF : CH_CR))
				term_m++;
			else
				term_m = (c == CH_CR) ? 1 : 0;

			if (term_m >= 4) begin
				lim = (lim_body < LEN_CAP) ? lim_body : LEN_CAP;
				bad = !len_found || len_bad || (len_neg && len_val != 32'd0)
					|| len_val > {1'b0, lim};
				if (bad) begin
					b.kind = KIND_BAD_LEN;
					due_beats.push_back(b);
					m_phase = PH_DEAD;
				end else if (len_val == 32'd0)
					fresh_header();
				else begin
					body_left = len_val[30:0];
					body_go = 1'b0;
					m_phase = PH_BODY;
				end
			end else if (hdr_cnt > lim_hdr) begin
				b.kind = KIND_NO_TERM;
				due_beats.push_back(b);
				m_phase = PH_DEAD;
			end
		end
	endtask

	// byte source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				deframe_byte(in_byte);
			if (src_span == 0) begin
				src_span = $urandom_range(16, 128);
				src_rate = 3 * $urandom_range(0, 2);
			end else
				src_span--;
			if (!in_valid || in_ready) begin
				if (src_gap != 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (stream_q.size() == 0)
					in_valid <= 1'b0;
				else if (!calm && $urandom_range(0, 15) < src_rate) begin
					src_gap = $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_byte <= stream_q.pop_front();
				end
			end
		end
	end

	// beat sink and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: kind %0d data %02h first %0b last %0b",
							kind, data_byte, first_of_body, last_of_body);
				end else begin
					want = due_beats.pop_front();
					if (kind !== want.kind || data_byte !== want.data
							|| first_of_body !== want.first || last_of_body !== want.last) begin
						errors++;
						if (errors <= 10)
							$display({"beat mismatch: exp kind %0d data %02h first %0b last %0b,",
								" got kind %0d data %02h first %0b last %0b"},
								want.kind, want.data, want.first, want.last,
								kind, data_byte, first_of_body, last_of_body);
					end
				end
			end
			if (snk_span == 0) begin
				snk_span = $urandom_range(16, 128);
				snk_rate = 3 * $urandom_range(0, 2);
			end else
				snk_span--;
			if (snk_gap != 0) begin
				snk_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) < snk_rate) begin
				snk_gap = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("[content_length_stream_deframer] ERROR");
		$finish;
	end

	task automatic settle();
		do
			@(negedge clk);
		while (stream_q.size() != 0 || in_valid || due_beats.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_HDR)
			lim_hdr = val[15:0];
		else
			lim_body = val;
		@(negedge clk);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			stage.push_back(s[i]);
	endtask

	task automatic put_crlf();
		stage.push_back(CH_CR);
		stage.push_back(CH_LF);
	endtask

	task automatic put_end(input bit crlf);
		if (crlf || $urandom_range(0, 1) == 0)
			put_crlf();
		else
			stage.push_back(CH_LF);
	endtask

	task automatic put_ws(input int n, input bit with_cr);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, with_cr ? 4 : 3))
				0:       c = 8'h20;
				1:       c = 8'h09;
				2:       c = 8'h0B;
				3:       c = 8'h0C;
				default: c = CH_CR;
			endcase
			stage.push_back(c);
		end
	endtask

	// no CR in filler lines, so no early terminator
	task automatic put_junk_line(input bit crlf);
		logic [7:0] c;
		repeat ($urandom_range(1, 16)) begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_LF || c == CH_CR);
			stage.push_back(c);
		end
		put_end(crlf);
	endtask

	task automatic ship(input int n);
		foreach (stage[i])
			stream_q.push_back(stage[i]);
		repeat (n)
			stream_q.push_back(8'($urandom_range(0, 255)));
		fed += stage.size() + n;
		stage.delete();
	endtask

	task automatic send_msg(input logic [31:0] n);
		int post;
		stage.delete();
		post = $urandom_range(0, 2);
		repeat ($urandom_range(0, 2))
			put_junk_line(1'b0);
		put_ws($urandom_range(0, 2), 1'b0);
		put_str("Content-Length:");
		put_ws($urandom_range(0, 2), 1'b1);
		case ($urandom_range(0, 3))
			0:       put_str("+");
			1:       if (n == 32'd0) put_str("-");
			default: begin end
		endcase
		if ($urandom_range(0, 5) == 0)
			put_str("00");
		put_str($sformatf("%0d", n));
		put_ws($urandom_range(0, 2), 1'b1);
		put_end(post == 0);
		for (int i = 0; i < post; i++)
			put_junk_line(i == post - 1);
		put_crlf();
		if (stage.size() > int'(lim_hdr) + 1) begin
			stage.delete();
			put_str($sformatf("Content-Length:%0d", n));
			put_crlf();
			put_crlf();
		end
		ship(n);
	endtask

	initial begin
		int          stop;
		logic [31:0] n, cap;
		logic [15:0] h;
		logic [30:0] b;
		logic [7:0]  c;

		restart_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// body byte extremes
		put_str("Content-Length: 1");
		put_crlf();
		put_crlf();
		stage.push_back(8'h00);
		ship(0);
		put_str("Content-Length: 1");
		put_crlf();
		put_crlf();
		stage.push_back(8'hFF);
		ship(0);
		// minus zero, empty body, next byte starts a header
		put_str("Content-Length: -0");
		put_crlf();
		put_crlf();
		ship(0);
		put_str("Content-Length:+3");
		put_crlf();
		put_crlf();
		ship(3);
		// wrong case, partial key, later length lines ignored
		put_str("content-length: 9");
		put_crlf();
		put_str("Content-Len: 5");
		put_crlf();
		put_str("Content-Length: 2");
		put_crlf();
		put_str("Content-Length: zz");
		put_crlf();
		put_crlf();
		ship(2);
		// all whitespace kinds around the value
		stage.push_back(8'h09);
		stage.push_back(8'h20);
		stage.push_back(8'h0B);
		stage.push_back(8'h0C);
		put_str("Content-Length:");
		stage.push_back(8'h09);
		put_str("007");
		stage.push_back(8'h20);
		stage.push_back(CH_CR);
		stage.push_back(8'h09);
		put_crlf();
		put_crlf();
		ship(7);
		// bare LF line ends
		put_str("X-Junk: a");
		stage.push_back(CH_LF);
		put_str("Content-Length: 4");
		stage.push_back(CH_LF);
		put_str("Y: b");
		put_crlf();
		put_crlf();
		ship(4);
		put_str("Content-Length: 000");
		put_crlf();
		put_crlf();
		ship(0);

		// header one byte over the limit, finished by the terminator
		settle();
		set_reg(CFG_MAX_HDR, 31'd19);
		send_msg(2);
		send_msg(1);
		send_msg(0);

		settle();
		set_reg(CFG_MAX_HDR, 31'd65535);
		set_reg(CFG_MAX_MSG, 31'd0);
		repeat (4) send_msg(0);

		settle();
		set_reg(CFG_MAX_MSG, 31'd5);
		send_msg(5);
		send_msg(5);
		send_msg(1);

		settle();
		set_reg(CFG_MAX_MSG, 31'h7FFF_FFFF);
		repeat (3) send_msg($urandom_range(1, 12));

		while (fed < 1000) begin
			settle();
			case ($urandom_range(0, 3))
				0:       h = 16'd65535;
				1:       h = 16'($urandom_range(24, 60));
				2:       h = 16'($urandom_range(61, 400));
				default: h = 16'($urandom_range(401, 65534));
			endcase
			case ($urandom_range(0, 4))
				0:       b = 31'd0;
				1:       b = 31'($urandom_range(1, 40));
				2:       b = MAX_MSG_RESET;
				3:       b = 31'h7FFF_FFFF;
				default: b = 31'($urandom_range(41, 32'h7FFF_FFFE));
			endcase
			if ($urandom_range(0, 1) == 0) begin
				set_reg(CFG_MAX_HDR, {15'd0, h});
				set_reg(CFG_MAX_MSG, b);
			end else begin
				set_reg(CFG_MAX_MSG, b);
				set_reg(CFG_MAX_HDR, {15'd0, h});
			end
			if (fed > 850)
				calm = 1'b1;
			stop = fed + $urandom_range(60, 200);
			cap = (lim_body < 31'd40) ? {1'b0, lim_body} : 32'd40;
			while (fed < stop) begin
				case ($urandom_range(0, 19))
					0:       n = cap;
					1:       n = 32'd0;
					2:       n = (lim_body < 31'd300) ? {1'b0, lim_body} : $urandom_range(41, 300);
					default: n = $urandom_range(0, (cap < 32'd12) ? cap : 32'd12);
				endcase
				send_msg(n);
			end
		end

		// one terminal error, then bytes that are dropped
		settle();
		calm = 1'b1;
		if ($urandom_range(0, 1) == 0) begin
			set_reg(CFG_MAX_HDR, ($urandom_range(0, 3) == 0) ? 31'd1 : 31'($urandom_range(2, 40)));
			repeat (int'(lim_hdr) + 1 + $urandom_range(0, 8)) begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == CH_CR);
				stage.push_back(c);
			end
			ship(20);
		end else begin
			set_reg(CFG_MAX_HDR, 31'd65535);
			case ($urandom_range(0, 9))
				0:       put_str("Accept: x");
				1:       put_str("Content-Length:  ");
				2:       put_str("Content-Length: -");
				3:       put_str("Content-Length: +-4");
				4:       put_str("Content-Length: 12a");
				5:       put_str("Content-Length: -7");
				6:       put_str("Content-Length: 99999999999");
				7:       put_str($sformatf("Content-Length: %0d", {1'b0, lim_body} + 32'd1));
				8:       put_str("Content-Length: 4 4");
				default: begin
					put_str("Content-Length: x");
					put_crlf();
					put_str("Content-Length: 3");
				end
			endcase
			put_crlf();
			put_crlf();
			ship(20);
		end
		settle();
		repeat (8) @(negedge clk);

		errors += due_beats.size();
		if (errors == 0)
			$display("[content_length_stream_deframer] OK");
		else
			$display("[content_length_stream_deframer] ERROR");
		$finish;
	end

endmodule

// ===== content_length_stream_deframer.f =====
design/clsd_pkg.sv
design/content_length_stream_deframer.sv
dv/tb_top.sv
